@@ design/csc_pkg.sv @@
// Shared types, constants and alphabet functions for the chained substitution cipher unit.
`timescale 1ns / 1ps

package csc_pkg;

    localparam int CODE_SPACE_DEF = 128;
    localparam int CMD_DEPTH_DEF  = 2;
    localparam int RES_DEPTH_DEF  = 4;
    localparam int ALPHA_LEN      = 65;

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_ENC   = 2'd1;
    localparam logic [1:0] MODE_DEC   = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    localparam logic [6:0] CH_UA    = 7'h41;
    localparam logic [6:0] CH_UZ    = 7'h5A;
    localparam logic [6:0] CH_LA    = 7'h61;
    localparam logic [6:0] CH_LZ    = 7'h7A;
    localparam logic [6:0] CH_0     = 7'h30;
    localparam logic [6:0] CH_9     = 7'h39;
    localparam logic [6:0] CH_PLUS  = 7'h2B;
    localparam logic [6:0] CH_SLASH = 7'h2F;
    localparam logic [6:0] CH_EQ    = 7'h3D;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_ENC,
        OP_DEC,
        OP_CLR
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [6:0] idx;
        logic [6:0] chr;
        logic       bad;
    } t_cmd;

    typedef struct packed {
        logic [6:0] char_out;
        logic       bad_char;
    } t_res;

    typedef struct packed {
        logic       bad;
        logic [6:0] idx;
    } t_alpha;

    localparam int CMD_W = $bits(t_cmd);
    localparam int RES_W = $bits(t_res);

    function automatic t_alpha alpha_index(input logic [6:0] c);
        t_alpha a;
        a.bad = 1'b0;
        a.idx = '0;
        priority if (c >= CH_UA && c <= CH_UZ) begin
            a.idx = c - CH_UA;
        end else if (c >= CH_LA && c <= CH_LZ) begin
            a.idx = c - CH_LA + 7'd26;
        end else if (c >= CH_0 && c <= CH_9) begin
            a.idx = c - CH_0 + 7'd52;
        end else if (c == CH_PLUS) begin
            a.idx = 7'd62;
        end else if (c == CH_SLASH) begin
            a.idx = 7'd63;
        end else if (c == CH_EQ) begin
            a.idx = 7'd64;
        end else begin
            a.bad = 1'b1;
        end
        return a;
    endfunction

    function automatic logic [6:0] alpha_char(input logic [6:0] idx);
        logic [6:0] c;
        priority if (idx < 7'd26) begin
            c = CH_UA + idx;
        end else if (idx < 7'd52) begin
            c = CH_LA + idx - 7'd26;
        end else if (idx < 7'd62) begin
            c = CH_0 + idx - 7'd52;
        end else if (idx == 7'd62) begin
            c = CH_PLUS;
        end else if (idx == 7'd63) begin
            c = CH_SLASH;
        end else begin
            c = CH_EQ;
        end
        return c;
    endfunction

endpackage

@@ design/csc_fifo.sv @@
// Small register-based FIFO used for the command queue and the result queue.
`timescale 1ns / 1ps

module csc_fifo #(
    parameter int WIDTH = csc_pkg::CMD_W,
    parameter int DEPTH = csc_pkg::CMD_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    import csc_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("fifo push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("fifo pop while empty");

endmodule

@@ design/csc_front.sv @@
// Front end: classifies an input beat into a command for the back end.
`timescale 1ns / 1ps

module csc_front (
    input  logic [1:0]    i_mode,
    input  logic [6:0]    i_char_in,
    input  logic [6:0]    i_entry_index,
    input  logic [6:0]    i_entry_char,
    output logic          o_keep,
    output csc_pkg::t_cmd o_cmd
);
    import csc_pkg::*;

    t_alpha w_alpha;

    always_comb begin
        w_alpha    = alpha_index(i_char_in);
        o_keep     = 1'b1;
        o_cmd.op   = OP_CLR;
        o_cmd.idx  = '0;
        o_cmd.chr  = i_char_in;
        o_cmd.bad  = 1'b0;
        unique case (i_mode)
            MODE_LOAD: begin
                o_cmd.op  = OP_LOAD;
                o_cmd.idx = i_entry_index;
                o_cmd.chr = i_entry_char;
                // drop loads beyond the alphabet
                o_keep    = (i_entry_index < 7'(ALPHA_LEN));
            end
            MODE_ENC: begin
                o_cmd.op  = OP_ENC;
                o_cmd.idx = w_alpha.idx;
                o_cmd.bad = w_alpha.bad;
            end
            MODE_DEC: begin
                o_cmd.op  = OP_DEC;
            end
            MODE_CLEAR: begin
                o_cmd.op  = OP_CLR;
            end
            default: begin
                o_cmd.op  = OP_CLR;
            end
        endcase
    end

endmodule

@@ design/csc_back.sv @@
// Back end: mask tables, chain index and the three-stage execution pipeline.
`timescale 1ns / 1ps

module csc_back #(
    parameter int CODE_SPACE = csc_pkg::CODE_SPACE_DEF,
    parameter int RES_DEPTH  = csc_pkg::RES_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_chain_enable,
    input  logic                           i_cmd_vld,
    input  csc_pkg::t_cmd                  i_cmd,
    output logic                           o_cmd_pop,
    input  logic [$clog2(RES_DEPTH+1)-1:0] i_res_count,
    output logic                           o_res_push,
    output csc_pkg::t_res                  o_res
);
    import csc_pkg::*;

    localparam int CS_AW = $clog2(CODE_SPACE);
    localparam int OW    = $clog2(RES_DEPTH+1) + 1;

    logic [6:0]            r_fwd_mem [ALPHA_LEN];
    logic [6:0]            r_rev_mem [CODE_SPACE];
    logic [CODE_SPACE-1:0] r_rev_vld;
    logic [6:0]            r_chain;
    logic [6:0]            n_chain;

    logic                  r_p2_vld;
    t_op                   r_p2_op;
    logic [6:0]            r_p2_idx;
    logic                  r_p2_bad;
    logic                  r_p2_hit;
    logic [6:0]            r_rev_q;

    logic                  r_p3_vld;
    logic                  r_p3_enc;
    logic [6:0]            r_p3_char;
    logic                  r_p3_bad;
    logic [6:0]            r_fwd_q;

    logic                  w_issue;
    logic [OW-1:0]         w_occ;
    logic [CS_AW-1:0]      w_rev_addr;
    logic [7:0]            w_diff;
    logic [6:0]            w_diff_mod;
    logic [7:0]            w_sum;
    logic [6:0]            w_sum_mod;
    logic [6:0]            w_fwd_addr;
    logic [6:0]            w_dec_idx;
    logic                  w_p3_take;

    // stage 1: issue while the result queue has room for everything in flight
    assign w_occ      = OW'(r_p2_vld) + OW'(r_p3_vld) + OW'(i_res_count);
    assign w_issue    = i_cmd_vld && (w_occ < OW'(RES_DEPTH));
    assign o_cmd_pop  = w_issue;
    assign w_rev_addr = CS_AW'(i_cmd.chr);

    always_ff @(posedge i_clk) begin
        if (w_issue && i_cmd.op == OP_LOAD) begin
            r_fwd_mem[i_cmd.idx] <= i_cmd.chr;
        end
        r_fwd_q <= r_fwd_mem[w_fwd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_issue && i_cmd.op == OP_LOAD) begin
            r_rev_mem[w_rev_addr] <= i_cmd.idx;
        end
        r_rev_q <= r_rev_mem[w_rev_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rev_vld <= '0;
            r_p2_vld  <= 1'b0;
            r_p3_vld  <= 1'b0;
            r_chain   <= '0;
        end else begin
            if (w_issue && i_cmd.op == OP_CLR) begin
                r_rev_vld <= '0;
            end else if (w_issue && i_cmd.op == OP_LOAD) begin
                r_rev_vld[w_rev_addr] <= 1'b1;
            end
            r_p2_vld <= w_issue;
            r_p3_vld <= w_p3_take;
            r_chain  <= n_chain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p2_op   <= i_cmd.op;
        r_p2_idx  <= i_cmd.idx;
        r_p2_bad  <= i_cmd.bad;
        r_p2_hit  <= r_rev_vld[w_rev_addr];
        r_p3_enc  <= (r_p2_op == OP_ENC);
        r_p3_char <= alpha_char(w_dec_idx);
        r_p3_bad  <= r_p2_bad && (r_p2_op == OP_ENC);
    end

    // stage 2: chain arithmetic mod 65, forward table address
    always_comb begin
        w_diff     = {1'b0, r_p2_idx} - {1'b0, r_chain};
        w_diff_mod = w_diff[7] ? (w_diff[6:0] + 7'(ALPHA_LEN)) : w_diff[6:0];
        w_sum      = {1'b0, r_chain} + {1'b0, r_rev_q};
        w_sum_mod  = (w_sum >= 8'(ALPHA_LEN)) ? 7'(w_sum - 8'(ALPHA_LEN)) : w_sum[6:0];
        w_fwd_addr = i_chain_enable ? w_diff_mod : r_p2_idx;
        w_dec_idx  = i_chain_enable ? w_sum_mod : r_rev_q;
        w_p3_take  = 1'b0;
        n_chain    = r_chain;
        if (r_p2_vld) begin
            unique case (r_p2_op)
                OP_ENC: begin
                    w_p3_take = 1'b1;
                    if (i_chain_enable) begin
                        n_chain = r_p2_idx;
                    end
                end
                OP_DEC: begin
                    w_p3_take = r_p2_hit;
                    if (i_chain_enable && r_p2_hit) begin
                        n_chain = w_sum_mod;
                    end
                end
                OP_CLR: begin
                    n_chain = '0;
                end
                default: begin
                    n_chain = r_chain;
                end
            endcase
        end
    end

    // stage 3: hand the result to the result queue
    assign o_res_push     = r_p3_vld;
    assign o_res.char_out = r_p3_enc ? r_fwd_q : r_p3_char;
    assign o_res.bad_char = r_p3_bad;

    a_chain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chain < 7'(ALPHA_LEN))
        else $error("chain index out of alphabet range");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && i_cmd.op == OP_CLR) |=> (r_rev_vld == '0))
        else $error("clear left reverse entries valid");

    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_occ <= OW'(RES_DEPTH))
        else $error("in-flight results exceed result queue space");

    a_dec_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p3_vld && !r_p3_enc) |-> !o_res.bad_char)
        else $error("decode result flagged bad");

endmodule

@@ design/chained_substitution_cipher_unit.sv @@
// Throughput: one input beat per cycle while full is low; the back end issues one
// command per cycle while the result queue has room for every command in flight.
// Reset (synchronous, active low): empties both queues, marks every reverse entry
// unused, zeroes the chain index and sets chain_enable to 1; forward entries stay
// undefined until loaded.
`timescale 1ns / 1ps

module chained_substitution_cipher_unit #(
    parameter int CODE_SPACE = csc_pkg::CODE_SPACE_DEF,
    parameter int CMD_DEPTH  = csc_pkg::CMD_DEPTH_DEF,
    parameter int RES_DEPTH  = csc_pkg::RES_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] i_mode,
    input  logic [6:0] i_char_in,
    input  logic [6:0] i_entry_index,
    input  logic [6:0] i_entry_char,
    output logic       empty,
    input  logic       pop,
    output logic [6:0] o_char_out,
    output logic       o_bad_char,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data
);
    import csc_pkg::*;

    localparam int RCW = $clog2(RES_DEPTH+1);

    logic                         r_chain_enable;
    logic                         w_keep;
    t_cmd                         w_front_cmd;
    logic                         w_cmd_push;
    logic [CMD_W-1:0]             w_cmd_data;
    logic                         w_cmd_empty;
    logic                         w_cmd_pop;
    logic [$clog2(CMD_DEPTH+1)-1:0] w_cmd_count;
    t_cmd                         w_cmd;
    logic                         w_res_push;
    t_res                         w_res;
    logic                         w_res_full;
    logic [RES_W-1:0]             w_res_data;
    logic [RCW-1:0]               w_res_count;
    t_res                         w_res_q;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain_enable <= 1'b1;
        end else if (i_cfg_valid) begin
            r_chain_enable <= i_cfg_data;
        end
    end

    csc_front u_front (
        .i_mode        (i_mode),
        .i_char_in     (i_char_in),
        .i_entry_index (i_entry_index),
        .i_entry_char  (i_entry_char),
        .o_keep        (w_keep),
        .o_cmd         (w_front_cmd)
    );

    assign w_cmd_push = push && !full && w_keep;

    csc_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_front_cmd),
        .o_full  (full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_data),
        .o_empty (w_cmd_empty),
        .o_count (w_cmd_count)
    );

    assign w_cmd = t_cmd'(w_cmd_data);

    csc_back #(
        .CODE_SPACE (CODE_SPACE),
        .RES_DEPTH  (RES_DEPTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_chain_enable (r_chain_enable),
        .i_cmd_vld      (!w_cmd_empty),
        .i_cmd          (w_cmd),
        .o_cmd_pop      (w_cmd_pop),
        .i_res_count    (w_res_count),
        .o_res_push     (w_res_push),
        .o_res          (w_res)
    );

    csc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop && !empty),
        .o_data  (w_res_data),
        .o_empty (empty),
        .o_count (w_res_count)
    );

    assign w_res_q    = t_res'(w_res_data);
    assign o_char_out = w_res_q.char_out;
    assign o_bad_char = w_res_q.bad_char;

    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full)
        else $error("result pushed into a full result queue");

    a_cmd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_count <= ($clog2(CMD_DEPTH+1))'(CMD_DEPTH))
        else $error("command queue count out of range");

    a_pop_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> !w_cmd_empty)
        else $error("back end took a command from an empty queue");

endmodule
